// File: rtl/core/prq_pkg.sv
// Shared constants, types and control structs for the priority ready queue.
`default_nettype none

package prq_pkg;

    localparam int MAX_THREADS = 64;
    localparam int LEVELS      = 32;
    localparam int THREAD_W    = $clog2(MAX_THREADS);
    localparam int LEVEL_W     = $clog2(LEVELS);

    typedef logic [THREAD_W-1:0] thread_t;
    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [LEVELS-1:0]   mask_t;

    // Request codes
    localparam logic [1:0] REQ_INS_TAIL = 2'd0;
    localparam logic [1:0] REQ_INS_HEAD = 2'd1;
    localparam logic [1:0] REQ_REMOVE   = 2'd2;
    localparam logic [1:0] REQ_SELECT   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_EMPTY      = 2'd1;
    localparam logic [1:0] ST_QUEUED     = 2'd2;
    localparam logic [1:0] ST_NOT_QUEUED = 2'd3;

    // Where the reported priority comes from
    typedef enum logic [1:0] {
        PSRC_ZERO,
        PSRC_LEVEL,
        PSRC_RAM
    } prio_src_t;

    // Controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       sel_pick;
        logic       sel_take;
        logic       unl_level;
        logic       link_empty;
        logic       link_nonempty;
        logic       unlink;
        logic       clr_thread;
        logic       res_en;
        logic [1:0] res_status;
        prio_src_t  res_prio;
        logic       load_out;
    } prq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       tid_queued;
        logic       level_busy;
        logic       sel_any;
    } prq_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/prq_if.sv
// Request and response channel interfaces of the priority ready queue.
`default_nettype none

interface prq_req_if
    import prq_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    thread_t    thread_id;
    level_t     priority_req;
    level_t     min_priority;

    modport source (
        output valid, req_type, thread_id, priority_req, min_priority,
        input  ready
    );
    modport sink (
        input  valid, req_type, thread_id, priority_req, min_priority,
        output ready
    );
endinterface

interface prq_rsp_if
    import prq_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] status;
    thread_t    out_thread;
    level_t     out_priority;
    mask_t      ready_summary;

    modport source (
        output valid, status, out_thread, out_priority, ready_summary,
        input  ready
    );
    modport sink (
        input  valid, status, out_thread, out_priority, ready_summary,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/prq_ram.sv
// Generic one-write, one-read RAM with registered read data.
`default_nettype none

module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port (old data on a same-address write)
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/prq_datapath.sv
// Datapath: link stores, queued flags, level mask, level search and result registers.
`default_nettype none

module prq_datapath
    import prq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire prq_cmd_t   cmd,
    output prq_stat_t       stat,
    input  wire logic [1:0] req_type,
    input  wire thread_t    thread_id,
    input  wire level_t     priority_req,
    input  wire level_t     min_priority,
    output logic [1:0]      status,
    output thread_t         out_thread,
    output level_t          out_priority,
    output mask_t           ready_summary
);

    logic [1:0]             req_type_reg;
    thread_t                tid_reg;
    level_t                 lv_reg;
    level_t                 minp_reg;
    logic [MAX_THREADS-1:0] queued_reg;
    mask_t                  mask_reg;
    logic [1:0]             res_status_reg;
    level_t                 res_prio_reg;
    logic [1:0]             out_status_reg;
    thread_t                out_thread_reg;
    level_t                 out_prio_reg;
    mask_t                  out_mask_reg;

    thread_t head_rd, tail_rd, next_rd, prev_rd;
    level_t  lvl_rd;

    mask_t   eligible;
    level_t  sel_level;
    logic    at_head, at_tail, ins_head;

    logic    head_we, tail_we, next_we, prev_we, lvl_we;
    thread_t head_wd, tail_wd, next_wa, next_wd, prev_wa, prev_wd;

    // Highest non-empty level at or above the minimum
    always_comb
    begin
        eligible  = mask_reg & ({LEVELS{1'b1}} << minp_reg);
        sel_level = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (eligible[i])
            begin
                sel_level = LEVEL_W'(i);
            end
        end
    end

    assign at_head  = (head_rd == tid_reg);
    assign at_tail  = (tail_rd == tid_reg);
    assign ins_head = (req_type_reg == REQ_INS_HEAD);

    // Store write steering for link, relink and unlink
    always_comb
    begin
        head_we = cmd.link_empty || (cmd.link_nonempty && ins_head)
                  || (cmd.unlink && at_head && !at_tail);
        head_wd = cmd.unlink ? next_rd : tid_reg;

        tail_we = cmd.link_empty || (cmd.link_nonempty && !ins_head)
                  || (cmd.unlink && at_tail && !at_head);
        tail_wd = cmd.unlink ? prev_rd : tid_reg;

        next_we = cmd.link_nonempty || (cmd.unlink && !at_head && !at_tail);
        prev_we = next_we;
        if (cmd.unlink)
        begin
            next_wa = prev_rd;
            next_wd = next_rd;
            prev_wa = next_rd;
            prev_wd = prev_rd;
        end
        else if (ins_head)
        begin
            next_wa = tid_reg;
            next_wd = head_rd;
            prev_wa = head_rd;
            prev_wd = tid_reg;
        end
        else
        begin
            next_wa = tail_rd;
            next_wd = tid_reg;
            prev_wa = tid_reg;
            prev_wd = tail_rd;
        end

        lvl_we = cmd.link_empty || cmd.link_nonempty;
    end

    prq_ram #(.WIDTH(THREAD_W), .DEPTH(LEVELS)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (lv_reg),
        .wdata (head_wd),
        .raddr (lv_reg),
        .rdata (head_rd)
    );

    prq_ram #(.WIDTH(THREAD_W), .DEPTH(LEVELS)) u_tail_ram (
        .clk   (clk),
        .we    (tail_we),
        .waddr (lv_reg),
        .wdata (tail_wd),
        .raddr (lv_reg),
        .rdata (tail_rd)
    );

    prq_ram #(.WIDTH(THREAD_W), .DEPTH(MAX_THREADS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_wa),
        .wdata (next_wd),
        .raddr (tid_reg),
        .rdata (next_rd)
    );

    prq_ram #(.WIDTH(THREAD_W), .DEPTH(MAX_THREADS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_wa),
        .wdata (prev_wd),
        .raddr (tid_reg),
        .rdata (prev_rd)
    );

    prq_ram #(.WIDTH(LEVEL_W), .DEPTH(MAX_THREADS)) u_level_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (tid_reg),
        .wdata (lv_reg),
        .raddr (tid_reg),
        .rdata (lvl_rd)
    );

    // Level mask and queued flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            queued_reg <= '0;
        end
        else if (cmd.link_empty)
        begin
            mask_reg[lv_reg]    <= 1'b1;
            queued_reg[tid_reg] <= 1'b1;
        end
        else if (cmd.link_nonempty)
        begin
            queued_reg[tid_reg] <= 1'b1;
        end
        else if (cmd.unlink)
        begin
            queued_reg[tid_reg] <= 1'b0;
            if (at_head && at_tail)
            begin
                mask_reg[lv_reg] <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            minp_reg     <= min_priority;
        end

        if (cmd.load_req)
        begin
            tid_reg <= thread_id;
        end
        else if (cmd.sel_take)
        begin
            tid_reg <= head_rd;
        end
        else if (cmd.clr_thread)
        begin
            tid_reg <= '0;
        end

        if (cmd.load_req)
        begin
            lv_reg <= priority_req;
        end
        else if (cmd.sel_pick)
        begin
            lv_reg <= sel_level;
        end
        else if (cmd.unl_level)
        begin
            lv_reg <= lvl_rd;
        end
    end

    // Result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.res_en)
        begin
            res_status_reg <= cmd.res_status;
            case (cmd.res_prio)
                PSRC_LEVEL: res_prio_reg <= lv_reg;
                PSRC_RAM:   res_prio_reg <= lvl_rd;
                default:    res_prio_reg <= '0;
            endcase
        end

        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_thread_reg <= tid_reg;
            out_prio_reg   <= res_prio_reg;
            out_mask_reg   <= mask_reg;
        end
    end

    assign stat.req_type   = req_type_reg;
    assign stat.tid_queued = queued_reg[tid_reg];
    assign stat.level_busy = mask_reg[lv_reg];
    assign stat.sel_any    = |eligible;

    assign status        = out_status_reg;
    assign out_thread    = out_thread_reg;
    assign out_priority  = out_prio_reg;
    assign ready_summary = out_mask_reg;

endmodule

`default_nettype wire

// File: rtl/core/prq_ctrl.sv
// Controller: sequences each request through the link store reads and writes.
`default_nettype none

module prq_ctrl
    import prq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire prq_stat_t stat,
    output prq_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_SEL_RD    = 4'd2;
    localparam logic [3:0] S_SEL_TAKE  = 4'd3;
    localparam logic [3:0] S_UNL_LEVEL = 4'd4;
    localparam logic [3:0] S_UNL_PTRS  = 4'd5;
    localparam logic [3:0] S_UNL_WR    = 4'd6;
    localparam logic [3:0] S_INS_DUP   = 4'd7;
    localparam logic [3:0] S_INS_PTR   = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.req_type) inside
                    REQ_SELECT:
                    begin
                        if (stat.sel_any)
                        begin
                            cmd.sel_pick = 1'b1;
                            state_next   = S_SEL_RD;
                        end
                        else
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            cmd.res_prio   = PSRC_ZERO;
                            cmd.clr_thread = 1'b1;
                            state_next     = S_DONE;
                        end
                    end
                    REQ_REMOVE:
                    begin
                        if (stat.tid_queued)
                        begin
                            state_next = S_UNL_LEVEL;
                        end
                        else
                        begin
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_NOT_QUEUED;
                            cmd.res_prio   = PSRC_ZERO;
                            state_next     = S_DONE;
                        end
                    end
                    REQ_INS_TAIL, REQ_INS_HEAD:
                    begin
                        if (stat.tid_queued)
                        begin
                            state_next = S_INS_DUP;
                        end
                        else if (stat.level_busy)
                        begin
                            state_next = S_INS_PTR;
                        end
                        else
                        begin
                            cmd.link_empty = 1'b1;
                            cmd.res_en     = 1'b1;
                            cmd.res_status = ST_OK;
                            cmd.res_prio   = PSRC_LEVEL;
                            state_next     = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            // Head pointer of the chosen level is on its way
            S_SEL_RD:
            begin
                state_next = S_SEL_TAKE;
            end
            S_SEL_TAKE:
            begin
                cmd.sel_take = 1'b1;
                state_next   = S_UNL_PTRS;
            end
            S_UNL_LEVEL:
            begin
                cmd.unl_level = 1'b1;
                state_next    = S_UNL_PTRS;
            end
            // Head and tail of the thread's level are on their way
            S_UNL_PTRS:
            begin
                state_next = S_UNL_WR;
            end
            S_UNL_WR:
            begin
                cmd.unlink     = 1'b1;
                cmd.res_en     = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_prio   = PSRC_LEVEL;
                state_next     = S_DONE;
            end
            S_INS_DUP:
            begin
                cmd.res_en     = 1'b1;
                cmd.res_status = ST_QUEUED;
                cmd.res_prio   = PSRC_RAM;
                state_next     = S_DONE;
            end
            S_INS_PTR:
            begin
                cmd.link_nonempty = 1'b1;
                cmd.res_en        = 1'b1;
                cmd.res_status    = ST_OK;
                cmd.res_prio      = PSRC_LEVEL;
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/priority_ready_queue.sv
// Top level of the priority ready queue: controller plus datapath.
`default_nettype none

// Ready queue of up to 64 threads over 32 priority levels (31 highest), kept
// as one doubly linked list per level plus a mask of non-empty levels. One
// request is worked at a time; each returns one response transaction carrying
// status, thread, priority and the level mask after the request. A remove
// waits on a chain of registered reads on the link stores (thread entry, then
// the level's head and tail) before its write; a select first reads the
// chosen level's head. A finished response waits in an output register, so
// the next request is worked while it is held. The queued flags clear on
// reset; the link stores need no clearing pass.
module priority_ready_queue
    import prq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    prq_req_if.sink   req,
    prq_rsp_if.source rsp
);

    prq_cmd_t  cmd;
    prq_stat_t stat;

    prq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    prq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req.req_type),
        .thread_id     (req.thread_id),
        .priority_req  (req.priority_req),
        .min_priority  (req.min_priority),
        .status        (rsp.status),
        .out_thread    (rsp.out_thread),
        .out_priority  (rsp.out_priority),
        .ready_summary (rsp.ready_summary)
    );

endmodule

`default_nettype wire

// File: rtl/core/prq_checker.sv
// Port-level assertions for the priority ready queue and their bind.
`default_nettype none

module prq_checker
    import prq_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] status,
    input wire thread_t    out_thread,
    input wire level_t     out_priority,
    input wire mask_t      ready_summary
);

    // One request in flight: no acceptance in the cycle after a transaction
    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready
    ) else $error("request accepted while another is in flight");

    // A stalled response holds
    a_rsp_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status)
            && $stable(out_thread) && $stable(out_priority) && $stable(ready_summary))
    ) else $error("stalled response changed");

    // Empty select reports thread and priority zero
    a_empty_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_EMPTY) |-> (out_thread == '0 && out_priority == '0)
    ) else $error("empty select with nonzero thread or priority");

    // An already queued thread sits on a non-empty level
    a_queued_level: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_QUEUED) |-> ready_summary[out_priority]
    ) else $error("queued thread reported on an empty level");

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .out_thread    (rsp.out_thread),
    .out_priority  (rsp.out_priority),
    .ready_summary (rsp.ready_summary)
);

`default_nettype wire

// File: bench/priority_ready_queue_tb.sv
// Testbench for priority_ready_queue: directed and random requests checked against a list scoreboard.
`default_nettype none

module priority_ready_queue_tb;
    import prq_pkg::*;

    // One request transaction and one response transaction
    typedef struct {
        logic [1:0] req_type;
        thread_t    tid;
        level_t     prio;
        level_t     minp;
    } rq_item_t;

    typedef struct {
        logic [1:0] status;
        thread_t    thr;
        level_t     prio;
        mask_t      summary;
    } rq_reply_t;

    localparam int NUM_PHASES = 5;
    localparam int PHASE_REQS = 230;
    // Per phase: sender idle percent, receiver stall percent, highest thread id of the favoured pool
    localparam int PH_SEND [NUM_PHASES] = '{0, 86, 0, 29, 0};
    localparam int PH_RECV [NUM_PHASES] = '{0, 0, 86, 29, 0};
    localparam int PH_POOL [NUM_PHASES] = '{63, 15, 15, 63, 15};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    prq_req_if req ();
    prq_rsp_if rsp ();

    priority_ready_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Shadow copy of the ready queue
    mask_t   sh_mask;
    thread_t sh_head   [LEVELS];
    thread_t sh_tail   [LEVELS];
    thread_t sh_next   [MAX_THREADS];
    thread_t sh_prev   [MAX_THREADS];
    level_t  sh_level  [MAX_THREADS];
    bit      sh_queued [MAX_THREADS];

    rq_item_t  req_backlog [$];
    rq_reply_t predicted_replies [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int pushed_cnt = 0;
    int accepted_cnt = 0;
    int err_count = 0;
    int status_hits [4] = '{0, 0, 0, 0};
    bit req_taken = 1'b0;

    rq_item_t  seen_req;
    rq_item_t  next_req;
    rq_reply_t want_rsp;

    // Take a queued thread out of its level list
    function automatic void detach_thread(thread_t t);
        level_t  lv;
        thread_t p;
        thread_t n;
        bit      at_head;
        bit      at_tail;
        lv = sh_level[t];
        p = sh_prev[t];
        n = sh_next[t];
        at_head = (sh_head[lv] == t);
        at_tail = (sh_tail[lv] == t);
        if (at_head && at_tail)
            sh_mask[lv] = 1'b0;
        else if (at_head)
            sh_head[lv] = n;
        else if (at_tail)
            sh_tail[lv] = p;
        else
        begin
            sh_next[p] = n;
            sh_prev[n] = p;
        end
        sh_queued[t] = 1'b0;
    endfunction

    // Put a thread at the head or tail of a level list
    function automatic void attach_thread(thread_t t, level_t lv, bit at_head);
        thread_t nb;
        if (!sh_mask[lv])
        begin
            sh_head[lv] = t;
            sh_tail[lv] = t;
            sh_mask[lv] = 1'b1;
        end
        else if (at_head)
        begin
            nb = sh_head[lv];
            sh_next[t] = nb;
            sh_prev[nb] = t;
            sh_head[lv] = t;
        end
        else
        begin
            nb = sh_tail[lv];
            sh_prev[t] = nb;
            sh_next[nb] = t;
            sh_tail[lv] = t;
        end
        sh_level[t] = lv;
        sh_queued[t] = 1'b1;
    endfunction

    // Apply one request to the shadow queue and return the response it should produce
    function automatic rq_reply_t serve_request(rq_item_t it);
        rq_reply_t r;
        mask_t     elig;
        int        lv;
        r.status = ST_OK;
        r.thr = '0;
        r.prio = '0;
        if (it.req_type == REQ_SELECT)
        begin
            elig = sh_mask & ~((mask_t'(1) << it.minp) - mask_t'(1));
            if (elig == '0)
                r.status = ST_EMPTY;
            else
            begin
                lv = LEVELS - 1;
                while (!elig[lv])
                    lv--;
                r.thr = sh_head[lv];
                r.prio = level_t'(lv);
                detach_thread(r.thr);
            end
        end
        else
        begin
            r.thr = it.tid;
            if (it.req_type == REQ_REMOVE)
            begin
                if (!sh_queued[it.tid])
                    r.status = ST_NOT_QUEUED;
                else
                begin
                    r.prio = sh_level[it.tid];
                    detach_thread(it.tid);
                end
            end
            else if (sh_queued[it.tid])
            begin
                r.status = ST_QUEUED;
                r.prio = sh_level[it.tid];
            end
            else
            begin
                attach_thread(it.tid, it.prio, it.req_type == REQ_INS_HEAD);
                r.prio = it.prio;
            end
        end
        r.summary = sh_mask;
        return r;
    endfunction

    function automatic void cmp_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
            err_count++;
        end
    endfunction

    task automatic push_req(logic [1:0] rt, int tid, int prio, int minp);
        rq_item_t it;
        it.req_type = rt;
        it.tid = thread_t'(tid);
        it.prio = level_t'(prio);
        it.minp = level_t'(minp);
        req_backlog.push_back(it);
        pushed_cnt++;
    endtask

    // Random mix weighted toward inserts into a few crowded levels, so lists grow long
    // and removes hit heads, tails and middles
    task automatic queue_random_requests(int n, int pool_hi);
        int         r;
        logic [1:0] rt;
        int         tid;
        int         prio;
        int         minp;
        int         hot [4];
        hot = '{0, 7, 8, 31};
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 30)
                rt = REQ_INS_TAIL;
            else if (r < 45)
                rt = REQ_INS_HEAD;
            else if (r < 70)
                rt = REQ_REMOVE;
            else
                rt = REQ_SELECT;
            tid = ($urandom_range(9) < 8) ? $urandom_range(pool_hi) : $urandom_range(63);
            prio = ($urandom_range(1) == 0) ? $urandom_range(31) : hot[$urandom_range(3)];
            minp = ($urandom_range(9) < 6) ? 0 : $urandom_range(31);
            push_req(rt, tid, prio, minp);
        end
    endtask

    // Hold off new requests until every pushed one is taken and every response is back
    task automatic drain_all();
        while (accepted_cnt != pushed_cnt || predicted_replies.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: new transaction on the falling edge once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req.valid || req_taken)
            begin
                req_taken = 1'b0;
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = req_backlog.pop_front();
                    req.req_type <= next_req.req_type;
                    req.thread_id <= next_req.tid;
                    req.priority_req <= next_req.prio;
                    req.min_priority <= next_req.minp;
                    req.valid <= 1'b1;
                end
                else
                    req.valid <= 1'b0;
            end
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on request acceptance, check on response acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                seen_req.req_type = req.req_type;
                seen_req.tid = req.thread_id;
                seen_req.prio = req.priority_req;
                seen_req.minp = req.min_priority;
                predicted_replies.push_back(serve_request(seen_req));
                accepted_cnt++;
                req_taken = 1'b1;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("response with none outstanding: status %0d thread %0d",
                           rsp.status, rsp.out_thread);
                    err_count++;
                end
                else
                begin
                    want_rsp = predicted_replies.pop_front();
                    cmp_field("status", want_rsp.status, rsp.status);
                    cmp_field("out_thread", want_rsp.thr, rsp.out_thread);
                    cmp_field("out_priority", want_rsp.prio, rsp.out_priority);
                    cmp_field("ready_summary", want_rsp.summary, rsp.ready_summary);
                    if (!$isunknown(rsp.status))
                        status_hits[rsp.status]++;
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        req.valid = 1'b0;
        req.req_type = REQ_INS_TAIL;
        req.thread_id = '0;
        req.priority_req = '0;
        req.min_priority = '0;
        rsp.ready = 1'b0;
        sh_mask = '0;
        foreach (sh_queued[i])
            sh_queued[i] = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty select, failed remove, head/middle/tail removal,
        // duplicate insert, min priority filtering, single element level
        push_req(REQ_SELECT, 0, 0, 0);
        push_req(REQ_REMOVE, 5, 0, 0);
        push_req(REQ_INS_TAIL, 0, 0, 0);
        push_req(REQ_INS_TAIL, 63, 31, 31);
        push_req(REQ_INS_HEAD, 1, 0, 0);
        push_req(REQ_INS_TAIL, 2, 0, 0);
        push_req(REQ_INS_TAIL, 0, 0, 0);
        push_req(REQ_INS_HEAD, 63, 5, 0);
        push_req(REQ_REMOVE, 1, 0, 0);
        push_req(REQ_INS_TAIL, 3, 0, 0);
        push_req(REQ_REMOVE, 2, 0, 0);
        push_req(REQ_REMOVE, 3, 0, 0);
        push_req(REQ_SELECT, 0, 0, 31);
        push_req(REQ_SELECT, 0, 0, 31);
        push_req(REQ_SELECT, 0, 0, 1);
        push_req(REQ_SELECT, 63, 31, 0);
        push_req(REQ_REMOVE, 0, 0, 0);
        push_req(REQ_INS_HEAD, 42, 16, 0);
        push_req(REQ_REMOVE, 42, 0, 0);
        push_req(REQ_SELECT, 63, 31, 31);
        drain_all();

        // Random phases with different idle and stall pressure; each ends fully drained
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            send_idle_pct = PH_SEND[ph];
            recv_stall_pct = PH_RECV[ph];
            queue_random_requests(PHASE_REQS, PH_POOL[ph]);
            drain_all();
        end

        recv_stall_pct = 0;
        repeat (12) @(posedge clk);

        $display("covered %0d requests in %0d idle/stall phases", accepted_cnt, NUM_PHASES);
        $display("responses: ok %0d, empty %0d, already queued %0d, not queued %0d",
                 status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_QUEUED],
                 status_hits[ST_NOT_QUEUED]);
        if (err_count == 0)
            $display("priority_ready_queue_tb: done, clean");
        else
            $display("priority_ready_queue_tb: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("priority_ready_queue_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
